FILE: hdl/gir_pkg.sv
// Shared types, constants and helpers for the glucose-insulin derivative pipeline.
// No dependencies; used by gir_mulq and glucose_insulin_ode_rhs.
package gir_pkg;

    typedef logic signed [63:0] t_q;
    typedef logic signed [65:0] t_sum;

    // Pipeline latencies
    localparam int MUL_LAT  = 4;
    localparam int DIV_LAT  = 8;
    localparam int PIPE_LAT = 18;

    // Configuration register indexes
    localparam logic [2:0] REG_GUT_GAINS   = 3'd0;
    localparam logic [2:0] REG_INS_GAINS   = 3'd1;
    localparam logic [2:0] REG_GLC_VOLUME  = 3'd2;
    localparam logic [2:0] REG_BASAL       = 3'd3;
    localparam logic [2:0] REG_TRANSFER    = 3'd4;
    localparam logic [2:0] REG_ACT_ONE     = 3'd5;
    localparam logic [2:0] REG_ACT_TWO     = 3'd6;
    localparam logic [2:0] REG_ACT_THREE   = 3'd7;
    localparam int         NUM_REGS        = 8;

    // Fixed-point constants
    localparam t_q ONE_Q32   = 64'sd4294967296;
    localparam t_q LIM_PROD  = 64'sd1152921504606846976;
    localparam t_q G_LOW_THR = 64'sd19327352832;   // 4.5 in Q.32
    localparam t_q G_REN_THR = 64'sd38654705664;   // 9.0 in Q.32

    // First-level product slots
    localparam int P_CARB  = 0;
    localparam int P_UG1   = 1;
    localparam int P_UG    = 2;
    localparam int P_UI1   = 3;
    localparam int P_UI    = 4;
    localparam int P_G     = 5;
    localparam int P_Q12   = 6;
    localparam int P_Q21   = 7;
    localparam int P_Q2OUT = 8;
    localparam int P_EGP   = 9;
    localparam int P_KEX8  = 10;
    localparam int P_KB    = 11;   // three slots
    localparam int P_KA    = 14;   // three slots
    localparam int NUM_PA  = 17;

    // Constant-divide lanes: carb scaling, low-glucose clamp, renal excretion
    localparam int DIV_CARB  = 0;
    localparam int DIV_F01   = 1;
    localparam int DIV_RENAL = 2;
    localparam int NUM_DIV   = 3;
    localparam logic [63:0] DIV_DEN [NUM_DIV] = '{64'd563, 64'd9, 64'd1000};
    localparam logic [63:0] DIV_PRE [NUM_DIV] = '{64'd3125, 64'd2, 64'd3};

    function automatic t_q sx48(input logic signed [47:0] v);
        return {{16{v[47]}}, v};
    endfunction

    function automatic t_q zx32(input logic [31:0] v);
        return {32'b0, v};
    endfunction

    function automatic t_sum sx64(input t_q v);
        return {{2{v[63]}}, v};
    endfunction

    function automatic logic signed [47:0] sat48(input t_sum v);
        if (v > 66'sd140737488355327) begin
            return 48'sh7FFF_FFFF_FFFF;
        end else if (v < -66'sd140737488355328) begin
            return 48'sh8000_0000_0000;
        end
        return v[47:0];
    endfunction

endpackage

FILE: hdl/glucose_insulin_ode_rhs.sv
// Hovorka glucose-insulin right-hand side: ten derivatives per item, fully pipelined.
// Depends on gir_pkg and gir_mulq.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-------------------------------------------
//  input     | start, busy        | i_carb_rate .. i_act_production (12 x 48)
//  result    | o_valid strobe     | o_d_gut_first .. o_d_act_production (10 x 48)
//  config    | i_cfg_we           | i_cfg_idx (3), i_cfg_data (64)
//
// One item enters per cycle; each result follows its transfer through the chain
// product -> product -> constant divide -> sum -> saturate.
// busy stays low: the pipeline always takes a new item and the receiver cannot stall.
// Reset clears the configuration registers and the valid bits.
module glucose_insulin_ode_rhs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [63:0]        i_cfg_data,
    input  logic signed [47:0] i_carb_rate,
    input  logic signed [47:0] i_insulin_rate,
    input  logic signed [47:0] i_gut_first,
    input  logic signed [47:0] i_gut_second,
    input  logic signed [47:0] i_depot_first,
    input  logic signed [47:0] i_depot_second,
    input  logic signed [47:0] i_glucose_plasma,
    input  logic signed [47:0] i_glucose_tissue,
    input  logic signed [47:0] i_plasma_insulin,
    input  logic signed [47:0] i_act_transport,
    input  logic signed [47:0] i_act_disposal,
    input  logic signed [47:0] i_act_production,
    output logic               o_valid,
    output logic signed [47:0] o_d_gut_first,
    output logic signed [47:0] o_d_gut_second,
    output logic signed [47:0] o_d_depot_first,
    output logic signed [47:0] o_d_depot_second,
    output logic signed [47:0] o_d_glucose_plasma,
    output logic signed [47:0] o_d_glucose_tissue,
    output logic signed [47:0] o_d_plasma_insulin,
    output logic signed [47:0] o_d_act_transport,
    output logic signed [47:0] o_d_act_disposal,
    output logic signed [47:0] o_d_act_production
);
    import gir_pkg::*;

    localparam int LVA_DLY  = DIV_LAT + DIV_LAT - MUL_LAT;   // level-one products to sum
    localparam int X1_DLY   = MUL_LAT + DIV_LAT + MUL_LAT;   // input rate to sum
    localparam int UIVI_DLY = DIV_LAT;
    localparam int CARB_DLY = DIV_LAT - MUL_LAT;

    logic [63:0]   r_cfg [NUM_REGS];
    logic [PIPE_LAT-1:0] r_vld;

    t_q            pa_a [NUM_PA];
    t_q            pa_b [NUM_PA];
    t_q            pa_p [NUM_PA];
    t_q            r_lva_d [LVA_DLY][NUM_PA];
    logic [1:0]    r_flag_d [LVA_DLY];
    t_q            r_x1_d [X1_DLY];
    t_q            r_uivi_d [UIVI_DLY];
    t_q            r_carb_d [CARB_DLY];
    t_q            uivi_p, f01g_p, renal_p, renal_in;
    t_q            div_in [NUM_DIV];
    t_q            div_out [NUM_DIV];
    logic [1:0]    n_flag;
    t_sum          n_sum [10];
    t_sum          r_sum [10];
    logic signed [47:0] r_out [10];
    t_q            t_f01c, t_fr;

    assign busy = 1'b0;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++) begin
                r_cfg[k] <= '0;
            end
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_LAT-2:0], start & ~busy};
        end
    end
    assign o_valid = r_vld[PIPE_LAT-1];

    // First-level product operands
    always_comb begin
        pa_a[P_CARB]  = sx48(i_carb_rate);
        pa_b[P_CARB]  = zx32(r_cfg[REG_GUT_GAINS][63:32]);
        pa_a[P_UG1]   = sx48(i_gut_first);
        pa_b[P_UG1]   = zx32(r_cfg[REG_GUT_GAINS][31:0]);
        pa_a[P_UG]    = sx48(i_gut_second);
        pa_b[P_UG]    = zx32(r_cfg[REG_GUT_GAINS][31:0]);
        pa_a[P_UI1]   = sx48(i_depot_first);
        pa_b[P_UI1]   = zx32(r_cfg[REG_INS_GAINS][63:32]);
        pa_a[P_UI]    = sx48(i_depot_second);
        pa_b[P_UI]    = zx32(r_cfg[REG_INS_GAINS][63:32]);
        pa_a[P_G]     = sx48(i_glucose_plasma);
        pa_b[P_G]     = zx32(r_cfg[REG_GLC_VOLUME][31:0]);
        pa_a[P_Q12]   = sx48(i_act_transport);
        pa_b[P_Q12]   = sx48(i_glucose_plasma);
        pa_a[P_Q21]   = zx32(r_cfg[REG_TRANSFER][63:32]);
        pa_b[P_Q21]   = sx48(i_glucose_tissue);
        pa_a[P_Q2OUT] = sx48(i_act_disposal);
        pa_b[P_Q2OUT] = sx48(i_glucose_tissue);
        pa_a[P_EGP]   = zx32(r_cfg[REG_BASAL][31:0]);
        pa_b[P_EGP]   = ONE_Q32 - sx48(i_act_production);
        pa_a[P_KEX8]  = zx32(r_cfg[REG_TRANSFER][31:0]);
        pa_b[P_KEX8]  = sx48(i_plasma_insulin);
        pa_a[P_KB]    = zx32(r_cfg[REG_ACT_ONE][63:32]);
        pa_b[P_KB]    = sx48(i_plasma_insulin);
        pa_a[P_KB+1]  = zx32(r_cfg[REG_ACT_TWO][63:32]);
        pa_b[P_KB+1]  = sx48(i_plasma_insulin);
        pa_a[P_KB+2]  = zx32(r_cfg[REG_ACT_THREE][63:32]);
        pa_b[P_KB+2]  = sx48(i_plasma_insulin);
        pa_a[P_KA]    = zx32(r_cfg[REG_ACT_ONE][31:0]);
        pa_b[P_KA]    = sx48(i_act_transport);
        pa_a[P_KA+1]  = zx32(r_cfg[REG_ACT_TWO][31:0]);
        pa_b[P_KA+1]  = sx48(i_act_disposal);
        pa_a[P_KA+2]  = zx32(r_cfg[REG_ACT_THREE][31:0]);
        pa_b[P_KA+2]  = sx48(i_act_production);
    end

    for (genvar k = 0; k < NUM_PA; k++) begin : g_pa
        gir_mulq #(.SHIFT((k == P_EGP) ? 24 : 32)) u_mul (
            .i_clk (i_clk),
            .i_a   (pa_a[k]),
            .i_b   (pa_b[k]),
            .o_p   (pa_p[k])
        );
    end

    // Second-level products from plasma glucose and depot outflow
    assign renal_in = pa_p[P_G] - G_REN_THR;

    gir_mulq #(.SHIFT(32)) u_uivi (
        .i_clk (i_clk),
        .i_a   (pa_p[P_UI]),
        .i_b   (zx32(r_cfg[REG_INS_GAINS][31:0])),
        .o_p   (uivi_p)
    );

    gir_mulq #(.SHIFT(24)) u_f01g (
        .i_clk (i_clk),
        .i_a   (zx32(r_cfg[REG_BASAL][63:32])),
        .i_b   (pa_p[P_G]),
        .o_p   (f01g_p)
    );

    gir_mulq #(.SHIFT(24)) u_renal (
        .i_clk (i_clk),
        .i_a   (renal_in),
        .i_b   ({32'b0, r_cfg[REG_GLC_VOLUME][63:32]}),
        .o_p   (renal_p)
    );

    // Floor divide by constants: reciprocal product, then one correction step
    assign div_in[DIV_CARB]  = pa_p[P_CARB];
    assign div_in[DIV_F01]   = f01g_p;
    assign div_in[DIV_RENAL] = renal_p;

    for (genvar k = 0; k < NUM_DIV; k++) begin : g_div
        localparam t_q DEN   = t_q'(DIV_DEN[k]);
        localparam t_q PRE   = t_q'(DIV_PRE[k]);
        localparam t_q RECIP = t_q'(64'hFFFF_FFFF_FFFF_FFFF / DIV_DEN[k]);

        t_q    r_n, r_m, q0, r_q0, r_t, r_m7, r_res;
        t_q    r_m_d [MUL_LAT];
        logic  r_neg, r_neg7;
        logic  r_neg_d [MUL_LAT];
        t_q    n_m, n_q, n_r;

        // Fold the sign so the divide works on a non-negative value
        assign n_m = r_n[63] ? (-r_n + (DEN - 64'sd1)) : r_n;
        assign n_r = r_m7 - r_t;
        assign n_q = (n_r >= DEN) ? (r_q0 + 64'sd1) : r_q0;

        gir_mulq #(.SHIFT(64)) u_recip (
            .i_clk (i_clk),
            .i_a   (r_m),
            .i_b   (RECIP),
            .o_p   (q0)
        );

        always_ff @(posedge i_clk) begin
            r_n   <= div_in[k] * PRE;
            r_m   <= n_m;
            r_neg <= r_n[63];
            r_m_d[0]   <= r_m;
            r_neg_d[0] <= r_neg;
            for (int j = 1; j < MUL_LAT; j++) begin
                r_m_d[j]   <= r_m_d[j-1];
                r_neg_d[j] <= r_neg_d[j-1];
            end
            r_t    <= q0 * DEN;
            r_q0   <= q0;
            r_m7   <= r_m_d[MUL_LAT-1];
            r_neg7 <= r_neg_d[MUL_LAT-1];
            r_res  <= r_neg7 ? -n_q : n_q;
        end

        assign div_out[k] = r_res;
    end

    // Glucose thresholds: bit 0 at or above 4.5, bit 1 at or above 9
    assign n_flag = {pa_p[P_G] >= G_REN_THR, pa_p[P_G] >= G_LOW_THR};

    // Align side terms with the divider outputs
    always_ff @(posedge i_clk) begin
        r_lva_d[0]  <= pa_p;
        r_flag_d[0] <= n_flag;
        for (int j = 1; j < LVA_DLY; j++) begin
            r_lva_d[j]  <= r_lva_d[j-1];
            r_flag_d[j] <= r_flag_d[j-1];
        end
        r_x1_d[0] <= sx48(i_insulin_rate);
        for (int j = 1; j < X1_DLY; j++) begin
            r_x1_d[j] <= r_x1_d[j-1];
        end
        r_uivi_d[0] <= uivi_p;
        for (int j = 1; j < UIVI_DLY; j++) begin
            r_uivi_d[j] <= r_uivi_d[j-1];
        end
        r_carb_d[0] <= div_out[DIV_CARB];
        for (int j = 1; j < CARB_DLY; j++) begin
            r_carb_d[j] <= r_carb_d[j-1];
        end
    end

    // Combine fluxes into the ten derivatives
    always_comb begin
        t_f01c = r_flag_d[LVA_DLY-1][0] ? {24'b0, r_cfg[REG_BASAL][63:32], 8'b0}
                                        : div_out[DIV_F01];
        t_fr   = r_flag_d[LVA_DLY-1][1] ? div_out[DIV_RENAL] : '0;
        n_sum[0] = sx64(r_carb_d[CARB_DLY-1]) - sx64(r_lva_d[LVA_DLY-1][P_UG1]);
        n_sum[1] = sx64(r_lva_d[LVA_DLY-1][P_UG1]) - sx64(r_lva_d[LVA_DLY-1][P_UG]);
        n_sum[2] = sx64(r_x1_d[X1_DLY-1]) - sx64(r_lva_d[LVA_DLY-1][P_UI1]);
        n_sum[3] = sx64(r_lva_d[LVA_DLY-1][P_UI1]) - sx64(r_lva_d[LVA_DLY-1][P_UI]);
        n_sum[4] = sx64(r_lva_d[LVA_DLY-1][P_UG]) - sx64(t_f01c) - sx64(t_fr)
                 - sx64(r_lva_d[LVA_DLY-1][P_Q12]) + sx64(r_lva_d[LVA_DLY-1][P_Q21])
                 + sx64(r_lva_d[LVA_DLY-1][P_EGP]);
        n_sum[5] = sx64(r_lva_d[LVA_DLY-1][P_Q12]) - sx64(r_lva_d[LVA_DLY-1][P_Q21])
                 - sx64(r_lva_d[LVA_DLY-1][P_Q2OUT]);
        n_sum[6] = sx64(r_uivi_d[UIVI_DLY-1]) - sx64(r_lva_d[LVA_DLY-1][P_KEX8]);
        for (int j = 0; j < 3; j++) begin
            n_sum[7+j] = sx64(r_lva_d[LVA_DLY-1][P_KB+j])
                       - sx64(r_lva_d[LVA_DLY-1][P_KA+j]);
        end
    end

    // Register sums, then saturate into the output registers
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 10; j++) begin
            r_sum[j] <= n_sum[j];
            r_out[j] <= sat48(r_sum[j]);
        end
    end

    assign o_d_gut_first      = r_out[0];
    assign o_d_gut_second     = r_out[1];
    assign o_d_depot_first    = r_out[2];
    assign o_d_depot_second   = r_out[3];
    assign o_d_glucose_plasma = r_out[4];
    assign o_d_glucose_tissue = r_out[5];
    assign o_d_plasma_insulin = r_out[6];
    assign o_d_act_transport  = r_out[7];
    assign o_d_act_disposal   = r_out[8];
    assign o_d_act_production = r_out[9];

endmodule

FILE: hdl/gir_mulq.sv
// Pipelined fixed-point product floor(a*b / 2^SHIFT), clamped to +/-2^60.
// Four register stages; 32x32 partial products. Depends on gir_pkg.
module gir_mulq #(
    parameter int SHIFT = 32
) (
    input  logic               i_clk,
    input  gir_pkg::t_q        i_a,
    input  gir_pkg::t_q        i_b,
    output gir_pkg::t_q        o_p
);
    import gir_pkg::*;

    logic          r_neg1, r_neg2, r_neg3;
    logic [63:0]   r_ma, r_mb;
    logic [63:0]   r_p00, r_p01, r_p10, r_p11;
    logic [127:0]  r_mag;
    t_q            r_p;
    logic [63:0]   n_ma, n_mb, q;
    logic          clamp, rem;
    t_q            n_p;

    // Take magnitudes
    assign n_ma = i_a[63] ? 64'(-i_a) : 64'(i_a);
    assign n_mb = i_b[63] ? 64'(-i_b) : 64'(i_b);

    // Floor toward minus infinity, clamp large magnitudes
    assign clamp = |r_mag[127:60+SHIFT];
    assign q     = r_mag[SHIFT+63:SHIFT];
    assign rem   = |r_mag[SHIFT-1:0];
    always_comb begin
        if (clamp) begin
            n_p = r_neg3 ? -LIM_PROD : LIM_PROD;
        end else if (r_neg3) begin
            n_p = -t_q'(q + 64'(rem));
        end else begin
            n_p = t_q'(q);
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg1 <= i_a[63] ^ i_b[63];
        r_ma   <= n_ma;
        r_mb   <= n_mb;
        r_neg2 <= r_neg1;
        r_p00  <= 64'(r_ma[31:0])  * 64'(r_mb[31:0]);
        r_p01  <= 64'(r_ma[31:0])  * 64'(r_mb[63:32]);
        r_p10  <= 64'(r_ma[63:32]) * 64'(r_mb[31:0]);
        r_p11  <= 64'(r_ma[63:32]) * 64'(r_mb[63:32]);
        r_neg3 <= r_neg2;
        r_mag  <= {r_p11, r_p00} + {32'b0, r_p01, 32'b0} + {32'b0, r_p10, 32'b0};
        r_p    <= n_p;
    end

    assign o_p = r_p;

endmodule
